/* src/qbe_pkg.sv */
package qbe_pkg;

    localparam int DEF_MAX_ROWS    = 256;
    localparam int DEF_MAX_COLS    = 256;
    localparam int DEF_STACK_DEPTH = 32;

    localparam int CFG_W   = 9;
    localparam int COUNT_W = 17;

    // register indexes
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // op codes
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // symbols
    localparam logic [1:0] SYM_ZERO  = 2'd0;
    localparam logic [1:0] SYM_ONE   = 2'd1;
    localparam logic [1:0] SYM_SPLIT = 2'd2;

endpackage

/* src/quadtree_bitmap_encoder.sv */
// Quadtree encoder for a bilevel bitmap. Load beats (tuser = 0) write one
// pixel each in row-major order; request beats (tuser = 1) return the next
// symbol of the depth-first quadtree code (0 all zero, 1 all one, 2
// divided) with tlast on the final symbol. A request scans its region one
// bitmap row per cycle out of the row-wide bitmap memory, then decides the
// symbol and, for a divided region, steps through four push slots before
// the symbol is offered on the output, where it may wait; pending regions
// live in a small stack memory, popped through a registered read and
// pushed one quarter per cycle. A request with nothing pending starts a new
// run over the whole bitmap and rewinds the load pointer. Loads that arrive
// while a run is pending are dropped. Writing num_cols re-derives the load
// row/column from the load count with a serial divider; s_tready stays low
// until the divider has handed back the result.
module quadtree_bitmap_encoder
    import qbe_pkg::*;
#(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    // stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] pixel
    input  logic        s_tuser,   // [0] operation
    // stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [1:0] symbol
    output logic        m_tlast,
    // config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RBW = $clog2(MAX_ROWS + 1);
    localparam int CBW = $clog2(MAX_COLS + 1);
    localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LVW = $clog2(STACK_DEPTH + 1);
    localparam int RGW = 2 * CBW + 2 * RBW;

    typedef struct packed {
        logic [CBW-1:0] l;
        logic [CBW-1:0] r;
        logic [RBW-1:0] t;
        logic [RBW-1:0] b;
    } region_t;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_POP    = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_PUSH   = 3'd4;
    localparam logic [2:0] ST_FIN    = 3'd5;

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] rows_reg, cols_reg;
    logic             cfg_wr;
    logic             div_start_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg      <= CFG_W'(1);
            cols_reg      <= CFG_W'(1);
            div_start_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (cfg_wr)
            begin
                unique case (paddr[2])
                    REG_ROWS: rows_reg <= pwdata[CFG_W-1:0];
                    REG_COLS:
                    begin
                        cols_reg      <= pwdata[CFG_W-1:0];
                        div_start_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_ROWS: prdata = 32'(rows_reg);
            REG_COLS: prdata = 32'(cols_reg);
            default:  prdata = '0;
        endcase
    end

    // clamped sizes: zero acts as one, above the maximum acts as the maximum
    logic [RBW-1:0] eff_rows;
    logic [CBW-1:0] eff_cols;

    always_comb
    begin
        if (rows_reg == '0)
            eff_rows = RBW'(1);
        else if (32'(rows_reg) > 32'(MAX_ROWS))
            eff_rows = RBW'(MAX_ROWS);
        else
            eff_rows = RBW'(rows_reg);
        if (cols_reg == '0)
            eff_cols = CBW'(1);
        else if (32'(cols_reg) > 32'(MAX_COLS))
            eff_cols = CBW'(MAX_COLS);
        else
            eff_cols = CBW'(cols_reg);
    end

    // ---------------- state ----------------
    logic [2:0]         state_reg, state_next;
    logic [COUNT_W-1:0] load_cnt_reg, load_cnt_next;
    logic [COUNT_W-1:0] ld_row_reg, ld_row_next;
    logic [CBW-1:0]     ld_col_reg, ld_col_next;
    logic [LVW-1:0]     level_reg, level_next;
    region_t            rg_reg, rg_next;
    logic [RBW-1:0]     scan_row_reg, scan_row_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               any_one_reg, any_one_next;
    logic               any_zero_reg, any_zero_next;
    logic [1:0]         sym_reg, sym_next;
    logic [1:0]         push_sel_reg, push_sel_next;
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         out_sym_reg, out_sym_next;
    logic               out_last_reg, out_last_next;

    logic               div_busy, div_done;
    logic [COUNT_W-1:0] div_quot;
    logic [CBW-1:0]     div_rem;

    logic               bm_we;
    logic [MAX_COLS-1:0] bm_rdata;
    logic               st_we;
    region_t            st_wdata;
    logic [RGW-1:0]     st_rdata;
    logic [LVW-1:0]     level_dec;

    logic               accept;
    logic               ld_full;
    logic [MAX_COLS-1:0] col_mask;
    logic [CBW-1:0]     vd;
    logic [RBW-1:0]     hd;
    logic               wide, tall;
    logic               push_en;
    region_t            push_rg;

    // held off until the divider has handed back the load row/column
    assign s_tready = (state_reg == ST_IDLE) && !div_busy && !div_start_reg && !div_done;
    assign accept   = s_tvalid && s_tready;
    assign ld_full  = 32'(load_cnt_reg) >= (32'(eff_rows) * 32'(eff_cols));
    assign level_dec = level_reg - 1'b1;

    always_comb
    begin
        for (int j = 0; j < MAX_COLS; j++)
        begin
            col_mask[j] = (32'(j) >= 32'(rg_reg.l)) && (32'(j) < 32'(rg_reg.r));
        end
    end

    // split point and quarter selection
    assign vd   = CBW'(({1'b0, rg_reg.l} + {1'b0, rg_reg.r} + 1'b1) >> 1);
    assign hd   = RBW'(({1'b0, rg_reg.t} + {1'b0, rg_reg.b} + 1'b1) >> 1);
    assign wide = (rg_reg.r - rg_reg.l) > CBW'(1);
    assign tall = (rg_reg.b - rg_reg.t) > RBW'(1);

    // quarters go on in reverse so the top-left comes off first
    always_comb
    begin
        push_rg = rg_reg;
        push_en = 1'b0;
        case (push_sel_reg)
            2'd0:
            begin
                push_en = wide && tall;
                push_rg = '{l: vd, r: rg_reg.r, t: hd, b: rg_reg.b};
            end
            2'd1:
            begin
                push_en = tall;
                push_rg = '{l: rg_reg.l, r: vd, t: hd, b: rg_reg.b};
            end
            2'd2:
            begin
                push_en = wide;
                push_rg = '{l: vd, r: rg_reg.r, t: rg_reg.t, b: hd};
            end
            default:
            begin
                push_en = 1'b1;
                push_rg = '{l: rg_reg.l, r: vd, t: rg_reg.t, b: hd};
            end
        endcase
    end

    assign st_wdata = push_rg;
    assign st_we    = (state_reg == ST_PUSH) && push_en &&
                      (32'(level_reg) < 32'(STACK_DEPTH));
    assign bm_we    = accept && (s_tuser == OP_LOAD) && (level_reg == '0) && !ld_full;

    always_comb
    begin
        state_next     = state_reg;
        load_cnt_next  = load_cnt_reg;
        ld_row_next    = ld_row_reg;
        ld_col_next    = ld_col_reg;
        level_next     = level_reg;
        rg_next        = rg_reg;
        scan_row_next  = scan_row_reg;
        rd_pend_next   = 1'b0;
        any_one_next   = any_one_reg;
        any_zero_next  = any_zero_reg;
        sym_next       = sym_reg;
        push_sel_next  = push_sel_reg;
        out_valid_next = out_valid_reg;
        out_sym_next   = out_sym_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        if (div_done)
        begin
            ld_row_next = div_quot;
            ld_col_next = div_rem;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && s_tuser == OP_LOAD)
                begin
                    if (bm_we)
                    begin
                        load_cnt_next = load_cnt_reg + 1'b1;
                        if (ld_col_reg + 1'b1 == eff_cols)
                        begin
                            ld_col_next = '0;
                            ld_row_next = ld_row_reg + 1'b1;
                        end
                        else
                        begin
                            ld_col_next = ld_col_reg + 1'b1;
                        end
                    end
                end
                else if (accept)
                begin
                    any_one_next  = 1'b0;
                    any_zero_next = 1'b0;
                    if (level_reg == '0)
                    begin
                        // new run over the whole bitmap
                        load_cnt_next = '0;
                        ld_row_next   = '0;
                        ld_col_next   = '0;
                        rg_next       = '{l: '0, r: eff_cols, t: '0, b: eff_rows};
                        scan_row_next = '0;
                        state_next    = ST_SCAN;
                    end
                    else
                    begin
                        level_next = level_dec;
                        state_next = ST_POP;
                    end
                end
            end
            ST_POP:
            begin
                rg_next       = region_t'(st_rdata);
                scan_row_next = rg_next.t;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (rd_pend_reg)
                begin
                    any_one_next  = any_one_reg  | (|(bm_rdata & col_mask));
                    any_zero_next = any_zero_reg | (|(~bm_rdata & col_mask));
                end
                if (scan_row_reg < rg_reg.b)
                begin
                    rd_pend_next  = 1'b1;
                    scan_row_next = scan_row_reg + 1'b1;
                end
                else if (!rd_pend_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!any_one_reg)
                    sym_next = SYM_ZERO;
                else if (!any_zero_reg)
                    sym_next = SYM_ONE;
                else
                    sym_next = SYM_SPLIT;
                push_sel_next = '0;
                state_next = (any_one_reg && any_zero_reg) ? ST_PUSH : ST_FIN;
            end
            ST_PUSH:
            begin
                if (st_we)
                    level_next = level_reg + 1'b1;
                push_sel_next = push_sel_reg + 1'b1;
                if (push_sel_reg == 2'd3)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_sym_next   = sym_reg;
                    out_last_next  = (level_reg == '0);
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            load_cnt_reg  <= '0;
            ld_row_reg    <= '0;
            ld_col_reg    <= '0;
            level_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            push_sel_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            load_cnt_reg  <= load_cnt_next;
            ld_row_reg    <= ld_row_next;
            ld_col_reg    <= ld_col_next;
            level_reg     <= level_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            push_sel_reg  <= push_sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rg_reg       <= rg_next;
        scan_row_reg <= scan_row_next;
        any_one_reg  <= any_one_next;
        any_zero_reg <= any_zero_next;
        sym_reg      <= sym_next;
        out_sym_reg  <= out_sym_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = 8'(out_sym_reg);
    assign m_tlast  = out_last_reg;

    // ---------------- submodules ----------------
    qbe_div #(
        .DW (CBW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (load_cnt_reg),
        .divisor  (eff_cols),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    qbe_bitmap_mem #(
        .ROWS (MAX_ROWS),
        .COLS (MAX_COLS)
    ) u_bitmap (
        .clk   (clk),
        .we    (bm_we),
        .wrow  (ld_row_reg[RAW-1:0]),
        .wcol  (ld_col_reg[CAW-1:0]),
        .wbit  (s_tdata[0]),
        .raddr (scan_row_reg[RAW-1:0]),
        .rdata (bm_rdata)
    );

    qbe_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (RGW)
    ) u_stack (
        .clk   (clk),
        .we    (st_we),
        .waddr (level_reg[SAW-1:0]),
        .wdata (st_wdata),
        .raddr (level_dec[SAW-1:0]),
        .rdata (st_rdata)
    );

    // ---------------- assertions ----------------
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(level_reg) <= 32'(STACK_DEPTH))
        else $error("stack level beyond depth");

    a_last_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast && state_reg == ST_IDLE) |-> (level_reg == '0))
        else $error("last symbol with regions pending");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        bm_we |-> (level_reg == '0) && !div_busy)
        else $error("pixel write during run or divide");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_row_reg <= rg_reg.b))
        else $error("scan row past region bottom");

endmodule

/* src/qbe_bitmap_mem.sv */
module qbe_bitmap_mem
    import qbe_pkg::*;
#(
    parameter int ROWS = DEF_MAX_ROWS,
    parameter int COLS = DEF_MAX_COLS,
    localparam int RAW = (ROWS > 1) ? $clog2(ROWS) : 1,
    localparam int CAW = (COLS > 1) ? $clog2(COLS) : 1
)
(
    input  logic            clk,
    input  logic            we,
    input  logic [RAW-1:0]  wrow,
    input  logic [CAW-1:0]  wcol,
    input  logic            wbit,
    input  logic [RAW-1:0]  raddr,
    output logic [COLS-1:0] rdata
);

    logic [COLS-1:0] mem [ROWS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wrow][wcol] <= wbit;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/qbe_stack_mem.sv */
module qbe_stack_mem
    import qbe_pkg::*;
#(
    parameter int DEPTH = DEF_STACK_DEPTH,
    parameter int WIDTH = 36,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/qbe_div.sv */
// restoring divider, one quotient bit per cycle
module qbe_div
    import qbe_pkg::*;
#(
    parameter int DW = 9
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [COUNT_W-1:0] dividend,
    input  logic [DW-1:0]      divisor,
    output logic               busy,
    output logic               done,
    output logic [COUNT_W-1:0] quot,
    output logic [DW-1:0]      rem
);

    localparam int CNT_W = $clog2(COUNT_W + 1);

    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [COUNT_W-1:0] q_reg, q_next;
    logic [DW-1:0]      r_reg, r_next;
    logic [DW-1:0]      d_reg, d_next;
    logic               done_reg, done_next;
    logic [DW:0]        trial;

    always_comb
    begin
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[COUNT_W-1]};
        if (start)
        begin
            cnt_next = CNT_W'(COUNT_W);
            q_next   = dividend;
            r_next   = '0;
            d_next   = divisor;
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = DW'(trial - {1'b0, d_reg});
                q_next = {q_reg[COUNT_W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial[DW-1:0];
                q_next = {q_reg[COUNT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy = (cnt_reg != '0);
    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
    import qbe_pkg::*;

    localparam int SIDE      = 256;
    localparam int DEPTH     = 32;
    localparam int SETTLE    = 300;
    localparam int MAX_CYC   = 2000000;

    typedef struct packed {
        logic op;
        logic pix;
    } beat_t;

    typedef struct packed {
        logic [1:0] sym;
        logic       last;
    } code_t;

    typedef struct {
        int l;
        int r;
        int t;
        int b;
    } quad_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [0] pixel
    logic        s_tuser;   // [0] operation
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [1:0] symbol
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    quadtree_bitmap_encoder u_top (.*);

    // pending stimulus and expected symbols
    beat_t  send_q[$];
    code_t  code_q[$];
    int     errors;
    int     cycles;
    int     send_idle;
    int     recv_idle;

    // mirror of the encoder
    bit     img[SIDE*SIDE];
    int     fill_cnt;
    quad_t  pend[DEPTH];
    int     pend_lvl;
    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] cols_reg;

    // stimulus-side bitmap used to size each run
    bit     gen_img[SIDE*SIDE];

    function automatic int clip(logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > SIDE)
            return SIDE;
        return int'(v);
    endfunction

    function automatic logic [1:0] uniformity(ref bit m[SIDE*SIDE], input quad_t q);
        bit ones;
        bit zeros;
        ones  = 1;
        zeros = 1;
        for (int i = q.t; i < q.b; i++)
            for (int j = q.l; j < q.r; j++)
                if (m[i*SIDE+j])
                    zeros = 0;
                else
                    ones = 0;
        if (ones)
            return SYM_ONE;
        if (zeros)
            return SYM_ZERO;
        return SYM_SPLIT;
    endfunction

    function automatic void push_quad(int l, int r, int t, int b);
        // overflow drops the quarter
        if (pend_lvl >= DEPTH)
            return;
        pend[pend_lvl] = '{l, r, t, b};
        pend_lvl++;
    endfunction

    function automatic void encode_beat(beat_t bt);
        int    rows;
        int    cols;
        quad_t q;
        code_t c;
        int    vd;
        int    hd;
        bit    wide;
        bit    tall;
        rows = clip(rows_reg);
        cols = clip(cols_reg);
        if (bt.op == OP_LOAD) begin
            if (pend_lvl != 0 || fill_cnt >= rows * cols)
                return;
            img[(fill_cnt / cols) * SIDE + fill_cnt % cols] = bt.pix;
            fill_cnt++;
            return;
        end
        if (pend_lvl == 0) begin
            fill_cnt = 0;
            push_quad(0, cols, 0, rows);
        end
        pend_lvl--;
        q = pend[pend_lvl];
        c.sym = uniformity(img, q);
        if (c.sym == SYM_SPLIT) begin
            vd   = (q.l + q.r + 1) >> 1;
            hd   = (q.t + q.b + 1) >> 1;
            wide = (q.r - q.l) > 1;
            tall = (q.b - q.t) > 1;
            // reverse order so top-left pops first
            if (wide && tall)
                push_quad(vd, q.r, hd, q.b);
            if (tall)
                push_quad(q.l, vd, hd, q.b);
            if (wide)
                push_quad(vd, q.r, q.t, hd);
            push_quad(q.l, vd, q.t, hd);
        end
        c.last = (pend_lvl == 0);
        code_q.push_back(c);
    endfunction

    // number of symbols in the code of gen_img over a region
    function automatic int code_len(int l, int r, int t, int b);
        int vd;
        int hd;
        int n;
        if (uniformity(gen_img, '{l, r, t, b}) != SYM_SPLIT)
            return 1;
        vd = (l + r + 1) >> 1;
        hd = (t + b + 1) >> 1;
        n  = 1 + code_len(l, vd, t, hd);
        if (r - l > 1)
            n += code_len(vd, r, t, hd);
        if (b - t > 1)
            n += code_len(l, vd, hd, b);
        if (r - l > 1 && b - t > 1)
            n += code_len(vd, r, hd, b);
        return n;
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // driver: one beat per handshake, mirror updated on acceptance
    always @(posedge clk)
    begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end
        else begin
            if (s_tvalid && s_tready)
                encode_beat('{s_tuser, s_tdata[0]});
            if (!s_tvalid || s_tready) begin
                if (send_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
                    beat_t bt;
                    bt = send_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= bt.op;
                    s_tdata  <= {7'd0, bt.pix};
                end
                else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: random backpressure, compare against the oldest expected symbol
    always @(posedge clk)
    begin
        m_tready <= rst_n && ($urandom_range(0, 99) >= recv_idle);
        if (rst_n && m_tvalid && m_tready) begin
            if (code_q.size() == 0) begin
                $error("unexpected symbol beat: symbol=%0d last=%0b", m_tdata[1:0], m_tlast);
                errors++;
            end
            else begin
                code_t c;
                c = code_q.pop_front();
                if (m_tdata[1:0] !== c.sym) begin
                    $error("symbol: expected %0d, got %0d", c.sym, m_tdata[1:0]);
                    errors++;
                end
                if (m_tlast !== c.last) begin
                    $error("last: expected %0b, got %0b", c.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYC) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic reg_write(logic idx, int v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {23'd0, CFG_W'(v)};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_ROWS)
            rows_reg = CFG_W'(v);
        else
            cols_reg = CFG_W'(v);
    endtask

    task automatic drain();
        while (send_q.size() > 0 || s_tvalid || code_q.size() > 0)
            @(posedge clk);
        // a trailing load can still be in flight
        repeat (SETTLE) @(posedge clk);
    endtask

    // one full run: load the bitmap, then request its whole code; noise mixed in
    task automatic queue_run(int dens, int noise);
        int rows;
        int cols;
        int n;
        rows = clip(rows_reg);
        cols = clip(cols_reg);
        for (int i = 0; i < rows * cols; i++) begin
            bit p;
            p = ($urandom_range(0, 99) < dens);
            gen_img[(i / cols) * SIDE + i % cols] = p;
            send_q.push_back('{OP_LOAD, p});
        end
        // surplus loads are ignored
        if (noise && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) send_q.push_back('{OP_LOAD, 1'($urandom)});
        n = code_len(0, cols, 0, rows);
        for (int k = 0; k < n; k++) begin
            send_q.push_back('{OP_REQUEST, 1'($urandom)});
            // loads during emission are dropped
            if (noise && k < n - 1 && $urandom_range(0, 9) == 0)
                send_q.push_back('{OP_LOAD, 1'($urandom)});
        end
        // a repeated request replays the code
        if (noise && $urandom_range(0, 5) == 0)
            repeat (n) send_q.push_back('{OP_REQUEST, 1'($urandom)});
    endtask

    task automatic random_sizes();
        case ($urandom_range(0, 9))
            0: begin reg_write(REG_ROWS, 0);   reg_write(REG_COLS, $urandom_range(1, 8)); end
            1: begin reg_write(REG_ROWS, 511); reg_write(REG_COLS, 1);                    end
            2: begin reg_write(REG_ROWS, 1);   reg_write(REG_COLS, 257);                  end
            3: begin reg_write(REG_ROWS, $urandom_range(9, 16)); reg_write(REG_COLS, 0);  end
            default: begin
                reg_write(REG_ROWS, $urandom_range(1, 8));
                reg_write(REG_COLS, $urandom_range(1, 8));
            end
        endcase
    endtask

    initial
    begin
        int sent;
        int idle_s[4];
        int idle_r[4];
        idle_s = '{0, 86, 0, 23};
        idle_r = '{0, 0, 86, 23};
        errors   = 0;
        cycles   = 0;
        send_idle = 0;
        recv_idle = 0;
        fill_cnt = 0;
        pend_lvl = 0;
        rows_reg = 1;
        cols_reg = 1;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'd0;
        s_tuser  = 1'b0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = 3'd0;
        pwdata   = 32'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: single pixel at reset sizes, both values
        send_q.push_back('{OP_LOAD, 1'b1});
        send_q.push_back('{OP_REQUEST, 1'b0});
        send_q.push_back('{OP_LOAD, 1'b0});
        send_q.push_back('{OP_REQUEST, 1'b1});
        send_q.push_back('{OP_REQUEST, 1'b0});  // repeat of the code
        drain();
        // 2x2 checkerboard: split plus four leaves
        reg_write(REG_ROWS, 2);
        reg_write(REG_COLS, 2);
        send_q.push_back('{OP_LOAD, 1'b1});
        send_q.push_back('{OP_LOAD, 1'b0});
        send_q.push_back('{OP_LOAD, 1'b0});
        send_q.push_back('{OP_LOAD, 1'b1});
        send_q.push_back('{OP_LOAD, 1'b1});     // too many loads
        repeat (2) send_q.push_back('{OP_REQUEST, 1'b0});
        send_q.push_back('{OP_LOAD, 1'b1});     // dropped mid-run
        repeat (3) send_q.push_back('{OP_REQUEST, 1'b1});
        drain();
        // odd sizes: 3x1 and 1x3 have empty halves
        reg_write(REG_ROWS, 3);
        reg_write(REG_COLS, 1);
        queue_run(50, 0);
        drain();
        reg_write(REG_ROWS, 1);
        reg_write(REG_COLS, 3);
        queue_run(50, 0);
        drain();
        // 16x16 bitmap, one set pixel at the far corner: deep split chain
        reg_write(REG_ROWS, 16);
        reg_write(REG_COLS, 16);
        for (int i = 0; i < 256; i++) begin
            gen_img[(i / 16) * SIDE + i % 16] = (i == 255);
            send_q.push_back('{OP_LOAD, gen_img[(i / 16) * SIDE + i % 16]});
        end
        repeat (code_len(0, 16, 0, 16)) send_q.push_back('{OP_REQUEST, 1'b0});
        drain();

        // random runs under each backpressure mix
        for (int ph = 0; ph < 4; ph++) begin
            send_idle = idle_s[ph];
            recv_idle = idle_r[ph];
            sent = 0;
            while (sent < 150) begin
                int q_mark;
                random_sizes();
                q_mark = send_q.size();
                repeat ($urandom_range(1, 3)) begin
                    case ($urandom_range(0, 3))
                        0: queue_run($urandom_range(0, 1) * 100, 1);
                        1: queue_run($urandom_range(85, 100), 1);
                        default: queue_run($urandom_range(20, 80), 1);
                    endcase
                end
                sent += send_q.size() - q_mark;
                // sender holds until every symbol is back
                drain();
            end
        end

        drain();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* files.f */
src/qbe_pkg.sv
src/qbe_bitmap_mem.sv
src/qbe_stack_mem.sv
src/qbe_div.sv
src/quadtree_bitmap_encoder.sv
sim/tb.sv
